[design/mrl2_pkg.sv]
// ----------------------------------------------------------------------------
// mrl2_pkg
// Shared types and constants for the relative L2 error sum block: transaction
// payloads, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mrl2_pkg;

    // Fixed widths of the transaction fields and of the internal state.
    localparam int FIELD_W  = 32;
    localparam int ETA_W    = 32;
    localparam int SUM_W    = 48;
    localparam int ENERGY_W = 64;
    localparam int ROOT_W   = 32;

    // Defaults for the top-level parameters.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Value of the offset register after reset.
    localparam logic [ETA_W-1:0] ETA_RESET = ETA_W'(66);

    // Largest value of the running total.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Input transaction: one computed and one reference coefficient.
    typedef struct packed {
        logic signed [FIELD_W-1:0] var_re;
        logic signed [FIELD_W-1:0] var_im;
        logic signed [FIELD_W-1:0] ref_re;
        logic signed [FIELD_W-1:0] ref_im;
        logic                      end_of_mode;
        logic                      end_of_all;
    } in_item_t;

    // Output transaction: the total and the saturation flag.
    typedef struct packed {
        logic [SUM_W-1:0] error_sum;
        logic             saturated;
    } out_item_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RE,
        S_MUL_IM,
        S_ACC_IM,
        S_ROOT_VAR,
        S_WAIT_VAR,
        S_ROOT_REF,
        S_WAIT_REF,
        S_DIVIDE,
        S_WAIT_DIV,
        S_ADD,
        S_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic mul_sel_im;
        logic acc;
        logic sqrt_start;
        logic sqrt_sel_ref;
        logic take_err;
        logic div_start;
        logic add_quot;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_busy;
        logic sqrt_done;
        logic div_busy;
        logic div_done;
        logic mode_end;
        logic run_end;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

[design/mrl2_isqrt.sv]
// ----------------------------------------------------------------------------
// mrl2_isqrt
// Iterative integer square root of a 64-bit value, rounded down. One result
// bit is settled per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrl2_isqrt
    import mrl2_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [ENERGY_W-1:0] operand,
    output logic                     busy,
    output logic                     done,
    output logic [ROOT_W-1:0]        root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [ENERGY_W-1:0] x_reg, x_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    // One digit step: bring down two operand bits and try the next root bit.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], x_reg[ENERGY_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    // Next-value logic for the iteration.
    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next    = x_reg << 2;
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[design/mrl2_div.sv]
// ----------------------------------------------------------------------------
// mrl2_div
// Restoring unsigned divider. One quotient bit per cycle. The divisor must be
// nonzero for a valid result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrl2_div
    import mrl2_pkg::*;
#(
    parameter int NUM_W = ROOT_W + FRAC_BITS_DEF,
    parameter int DEN_W = ROOT_W + 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  busy,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    // The numerator register shifts out dividend bits and shifts in quotient bits.
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] diff;
    logic           fits;

    // One restoring step.
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
    end

    // Next-value logic for the iteration.
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

[design/mrl2_datapath.sv]
// ----------------------------------------------------------------------------
// mrl2_datapath
// Squaring, saturating energy accumulation, root and division units, the
// running total and the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mrl2_datapath
    import mrl2_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire in_item_t         in_data,
    input  wire logic             cfg_write,
    input  wire logic [ETA_W-1:0] cfg_data,
    input  wire ctrl_cmd_t        cmd,
    output ctrl_status_t          status,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int NUM_W  = ROOT_W + FRAC_BITS;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int QX_W   = (NUM_W > SUM_W) ? NUM_W : SUM_W;

    // Magnitude of the low DATA_WIDTH bits read as two's complement.
    function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [FIELD_W-1:0] raw);
        logic [DATA_WIDTH-1:0] low;
        low = raw[DATA_WIDTH-1:0];
        return low[DATA_WIDTH-1] ? (~low + DATA_WIDTH'(1)) : low;
    endfunction

    logic [DATA_WIDTH-1:0] var_re_reg, var_re_next;
    logic [DATA_WIDTH-1:0] var_im_reg, var_im_next;
    logic [DATA_WIDTH-1:0] ref_re_reg, ref_re_next;
    logic [DATA_WIDTH-1:0] ref_im_reg, ref_im_next;
    logic                  eom_reg, eom_next;
    logic                  eoa_reg, eoa_next;
    logic [PROD_W-1:0]     prod_var_reg, prod_var_next;
    logic [PROD_W-1:0]     prod_ref_reg, prod_ref_next;
    logic [ENERGY_W-1:0]   var_energy_reg, var_energy_next;
    logic [ENERGY_W-1:0]   ref_energy_reg, ref_energy_next;
    logic [ROOT_W-1:0]     err_root_reg, err_root_next;
    logic                  den_zero_reg, den_zero_next;
    logic [SUM_W-1:0]      running_sum_reg, running_sum_next;
    logic                  overflow_seen_reg, overflow_seen_next;
    logic [ETA_W-1:0]      eta_reg, eta_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;

    logic [DATA_WIDTH-1:0] op_var, op_ref;
    logic [ENERGY_W:0]     var_sum, ref_sum;
    logic [ENERGY_W-1:0]   sqrt_operand;
    logic [ROOT_W-1:0]     sqrt_root;
    logic                  sqrt_busy, sqrt_done;
    logic [NUM_W-1:0]      div_numer;
    logic [DEN_W-1:0]      div_denom;
    logic [NUM_W-1:0]      div_quot;
    logic                  div_busy, div_done;
    logic [QX_W-1:0]       quot_ext;
    logic [SUM_W-1:0]      quot_sel;
    logic                  quot_flag;
    logic [SUM_W:0]        total;

    // Squaring operands: real parts first, then imaginary parts.
    assign op_var = cmd.mul_sel_im ? var_im_reg : var_re_reg;
    assign op_ref = cmd.mul_sel_im ? ref_im_reg : ref_re_reg;

    // Energy sums with a carry bit for saturation.
    assign var_sum = {1'b0, var_energy_reg} + {1'b0, ENERGY_W'(prod_var_reg)};
    assign ref_sum = {1'b0, ref_energy_reg} + {1'b0, ENERGY_W'(prod_ref_reg)};

    // Operands of the shared root unit and the divider.
    assign sqrt_operand = cmd.sqrt_sel_ref ? ref_energy_reg : var_energy_reg;
    assign div_numer    = NUM_W'(err_root_reg) << FRAC_BITS;
    assign div_denom    = DEN_W'(sqrt_root) + DEN_W'(eta_reg);

    // Quotient with clamping and the zero-divisor rule.
    always_comb
    begin
        quot_ext = QX_W'(div_quot);
        if (den_zero_reg)
        begin
            quot_flag = (err_root_reg != '0);
            quot_sel  = quot_flag ? SUM_MAX : '0;
        end
        else if (quot_ext > QX_W'(SUM_MAX))
        begin
            quot_flag = 1'b1;
            quot_sel  = SUM_MAX;
        end
        else
        begin
            quot_flag = 1'b0;
            quot_sel  = quot_ext[SUM_W-1:0];
        end
        total = {1'b0, running_sum_reg} + {1'b0, quot_sel};
    end

    // Shared square root unit.
    mrl2_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (sqrt_operand),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // Divider for the normalized error.
    mrl2_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next-value logic for the datapath registers.
    always_comb
    begin
        var_re_next        = var_re_reg;
        var_im_next        = var_im_reg;
        ref_re_next        = ref_re_reg;
        ref_im_next        = ref_im_reg;
        eom_next           = eom_reg;
        eoa_next           = eoa_reg;
        prod_var_next      = prod_var_reg;
        prod_ref_next      = prod_ref_reg;
        var_energy_next    = var_energy_reg;
        ref_energy_next    = ref_energy_reg;
        err_root_next      = err_root_reg;
        den_zero_next      = den_zero_reg;
        running_sum_next   = running_sum_reg;
        overflow_seen_next = overflow_seen_reg;
        eta_next           = cfg_write ? cfg_data : eta_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_data_next      = out_data_reg;

        if (cmd.load)
        begin
            var_re_next = mag_of(in_data.var_re);
            var_im_next = mag_of(in_data.var_im);
            ref_re_next = mag_of(in_data.ref_re);
            ref_im_next = mag_of(in_data.ref_im);
            eom_next    = in_data.end_of_mode;
            eoa_next    = in_data.end_of_all;
        end

        if (cmd.mul_en)
        begin
            prod_var_next = PROD_W'(op_var) * PROD_W'(op_var);
            prod_ref_next = PROD_W'(op_ref) * PROD_W'(op_ref);
        end

        if (cmd.take_err)
        begin
            err_root_next = sqrt_root;
        end

        if (cmd.div_start)
        begin
            den_zero_next = (div_denom == '0);
        end

        if (cmd.acc)
        begin
            var_energy_next    = var_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : var_sum[ENERGY_W-1:0];
            ref_energy_next    = ref_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : ref_sum[ENERGY_W-1:0];
            overflow_seen_next = overflow_seen_reg || var_sum[ENERGY_W] || ref_sum[ENERGY_W];
        end
        else if (cmd.add_quot)
        begin
            // Close the mode: add the quotient and clear the energies.
            running_sum_next   = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
            overflow_seen_next = overflow_seen_reg || quot_flag || total[SUM_W];
            var_energy_next    = '0;
            ref_energy_next    = '0;
        end
        else if (cmd.emit)
        begin
            // Publish the total and start a new run.
            out_valid_next          = 1'b1;
            out_data_next.error_sum = running_sum_reg;
            out_data_next.saturated = overflow_seen_reg;
            running_sum_next        = '0;
            overflow_seen_next      = 1'b0;
        end
    end

    // Accumulation and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_energy_reg    <= '0;
            ref_energy_reg    <= '0;
            running_sum_reg   <= '0;
            overflow_seen_reg <= 1'b0;
            eta_reg           <= ETA_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            var_energy_reg    <= var_energy_next;
            ref_energy_reg    <= ref_energy_next;
            running_sum_reg   <= running_sum_next;
            overflow_seen_reg <= overflow_seen_next;
            eta_reg           <= eta_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        var_re_reg   <= var_re_next;
        var_im_reg   <= var_im_next;
        ref_re_reg   <= ref_re_next;
        ref_im_reg   <= ref_im_next;
        eom_reg      <= eom_next;
        eoa_reg      <= eoa_next;
        prod_var_reg <= prod_var_next;
        prod_ref_reg <= prod_ref_next;
        err_root_reg <= err_root_next;
        den_zero_reg <= den_zero_next;
        out_data_reg <= out_data_next;
    end

    // Status toward the controller.
    always_comb
    begin
        status.sqrt_busy = sqrt_busy;
        status.sqrt_done = sqrt_done;
        status.div_busy  = div_busy;
        status.div_done  = div_done;
        status.mode_end  = eom_reg || eoa_reg;
        status.run_end   = eoa_reg;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Closing a mode always leaves both energies empty.
    a_energy_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_quot |=> (var_energy_reg == '0) && (ref_energy_reg == '0))
        else $error("energies not cleared after mode end");

    // Emitting a result presents it and restarts the total and the flag.
    a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && (running_sum_reg == '0) && !overflow_seen_reg)
        else $error("emit did not present a result and clear the run");

endmodule

`default_nettype wire

[design/mrl2_ctrl.sv]
// ----------------------------------------------------------------------------
// mrl2_ctrl
// Controller state machine: sequences squaring, accumulation, the two roots,
// the division, the total update and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mrl2_ctrl
    import mrl2_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_MUL_RE;
            S_MUL_RE:   state_next = S_MUL_IM;
            S_MUL_IM:   state_next = S_ACC_IM;
            S_ACC_IM:   state_next = status.mode_end ? S_ROOT_VAR : S_IDLE;
            S_ROOT_VAR: state_next = S_WAIT_VAR;
            S_WAIT_VAR: if (status.sqrt_done) state_next = S_ROOT_REF;
            S_ROOT_REF: state_next = S_WAIT_REF;
            S_WAIT_REF: if (status.sqrt_done) state_next = S_DIVIDE;
            S_DIVIDE:   state_next = S_WAIT_DIV;
            S_WAIT_DIV: if (status.div_done) state_next = S_ADD;
            S_ADD:      state_next = status.run_end ? S_EMIT : S_IDLE;
            S_EMIT:     if (status.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_MUL_RE:   cmd.mul_en = 1'b1;
            S_MUL_IM:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel_im = 1'b1;
                cmd.acc        = 1'b1;
            end
            S_ACC_IM:   cmd.acc = 1'b1;
            S_ROOT_VAR: cmd.sqrt_start = 1'b1;
            S_WAIT_VAR: cmd.take_err = status.sqrt_done;
            S_ROOT_REF:
            begin
                cmd.sqrt_start   = 1'b1;
                cmd.sqrt_sel_ref = 1'b1;
            end
            S_WAIT_REF: cmd.div_start = status.sqrt_done;
            S_DIVIDE:   cmd.div_start = 1'b0;
            S_WAIT_DIV: cmd.add_quot = 1'b0;
            S_ADD:      cmd.add_quot = 1'b1;
            S_EMIT:     cmd.emit = status.out_free;
            default:    cmd = '0;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The root unit is only started when it is free.
    a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> !status.sqrt_busy)
        else $error("square root started while busy");

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("division started while busy");

    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over a pending transaction");

endmodule

`default_nettype wire

[design/mode_relative_l2_error_sum.sv]
// ----------------------------------------------------------------------------
// mode_relative_l2_error_sum
// Sequence: an item that does not end a mode passes through the accepting
// idle state, the two-phase squaring and the second accumulation step. An item
// that ends a mode then runs the shared bit-per-step square root twice, the
// bit-per-step divider and the total update; a final item then waits to
// emit while an earlier result is still stalled. No new item is taken before
// the last one is through. Reset clears all sums, the flag and the output
// valid; eta returns to 66.
// ----------------------------------------------------------------------------
`default_nettype none

module mode_relative_l2_error_sum
    import mrl2_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [ETA_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // The offset register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer.
    mrl2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    mrl2_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[tb/mrl2_checker.sv]
// ----------------------------------------------------------------------------
// mrl2_checker
// Watches the coefficient, result and offset channels of the relative L2 error
// sum block. It keeps its own copy of the energies, the running total, the
// saturation flag and eta, predicts the total at the end of each run and
// compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module mrl2_checker
    import mrl2_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire in_item_t         in_data,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire out_item_t        out_data,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [ETA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // Predicted block state.
    logic [ENERGY_W-1:0] var_power;
    logic [ENERGY_W-1:0] ref_power;
    logic [SUM_W-1:0]    total_acc;
    logic                clipped;
    logic [ETA_W-1:0]    eta_copy;

    // Totals still awaited from the block, oldest first.
    out_item_t pending_totals[$];
    int        failures;

    // Magnitude of the low DATA_WIDTH bits read as two's complement.
    function automatic logic [63:0] coeff_magnitude(logic [FIELD_W-1:0] raw);
        logic signed [DATA_WIDTH-1:0] narrow;
        logic signed [64:0]           wide;
        narrow = raw[DATA_WIDTH-1:0];
        wide = narrow;
        if (wide < 0)
            wide = -wide;
        return wide[63:0];
    endfunction

    // Squared magnitude of one complex coefficient.
    function automatic logic [63:0] pair_power(logic [FIELD_W-1:0] re, logic [FIELD_W-1:0] im);
        logic [63:0] a;
        logic [63:0] b;
        a = coeff_magnitude(re);
        b = coeff_magnitude(im);
        return a * a + b * b;
    endfunction

    // Largest r with r*r <= x, found one result bit at a time from the top.
    function automatic logic [ROOT_W-1:0] floor_root(logic [ENERGY_W-1:0] x);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] trial;
        r = '0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = r | (ROOT_W'(1) << i);
            if (64'(trial) * 64'(trial) <= x)
                r = trial;
        end
        return r;
    endfunction

    // Energy accumulation that holds at the top value on overflow.
    function automatic logic [ENERGY_W-1:0] clip_add(logic [ENERGY_W-1:0] acc,
                                                     logic [ENERGY_W-1:0] addend);
        logic [ENERGY_W:0] wide;
        wide = {1'b0, acc} + {1'b0, addend};
        if (wide[ENERGY_W])
        begin
            clipped = 1'b1;
            return '1;
        end
        return wide[ENERGY_W-1:0];
    endfunction

    // Close a mode: relative norm quotient added to the running total.
    task automatic finish_mode();
        logic [63:0]    err_norm;
        logic [63:0]    divisor;
        logic [63:0]    quot;
        logic [SUM_W:0] wide_sum;
        err_norm = 64'(floor_root(var_power));
        divisor = 64'(floor_root(ref_power)) + 64'(eta_copy);
        if (divisor == 0)
        begin
            if (err_norm == 0)
                quot = 0;
            else
            begin
                quot = 64'(SUM_MAX);
                clipped = 1'b1;
            end
        end
        else
        begin
            quot = (err_norm << FRAC_BITS) / divisor;
            if (quot > 64'(SUM_MAX))
            begin
                quot = 64'(SUM_MAX);
                clipped = 1'b1;
            end
        end
        wide_sum = {1'b0, total_acc} + {1'b0, quot[SUM_W-1:0]};
        if (wide_sum[SUM_W])
        begin
            total_acc = SUM_MAX;
            clipped = 1'b1;
        end
        else
            total_acc = wide_sum[SUM_W-1:0];
        var_power = '0;
        ref_power = '0;
    endtask

    // Fold one accepted coefficient transaction into the predicted state.
    task automatic absorb_coefficient(in_item_t it);
        out_item_t want;
        var_power = clip_add(var_power, pair_power(it.var_re, it.var_im));
        ref_power = clip_add(ref_power, pair_power(it.ref_re, it.ref_im));
        if (it.end_of_mode || it.end_of_all)
            finish_mode();
        if (it.end_of_all)
        begin
            want.error_sum = total_acc;
            want.saturated = clipped;
            pending_totals.push_back(want);
            total_acc = '0;
            clipped = 1'b0;
        end
    endtask

    // One line per mismatch, and a count of them.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        failures++;
    endtask

    // Compare one result transaction with the oldest prediction.
    task automatic check_total(out_item_t got);
        out_item_t want;
        if (pending_totals.size() == 0)
        begin
            report_mismatch("unexpected result transaction", 64'(got.error_sum), 0);
            return;
        end
        want = pending_totals.pop_front();
        if (got.error_sum != want.error_sum)
            report_mismatch("error_sum", 64'(got.error_sum), 64'(want.error_sum));
        if (got.saturated != want.saturated)
            report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
    endtask

    // Sample all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_power = '0;
            ref_power = '0;
            total_acc = '0;
            clipped = 1'b0;
            eta_copy = ETA_RESET;
            pending_totals.delete();
            failures = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                eta_copy = cfg_data;
            if (in_valid && !in_stall)
                absorb_coefficient(in_data);
            if (out_valid && !out_stall)
                check_total(out_data);
            fail_count <= failures;
            outstanding <= pending_totals.size();
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the relative L2 error sum block with directed corner cases (extreme
// coefficients, energy, quotient and total saturation, zero divisor, end of
// all without end of mode) and then with random runs of modes under several
// eta settings, with random idle bursts on both channels. A separate checker
// predicts and compares the results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mrl2_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    in_item_t         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [ETA_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    logic             cfg_ready;
    out_item_t        out_data;

    int   fail_count;
    int   outstanding;
    logic idle_on    = 1'b1;
    logic quiet_tail = 1'b0;
    int   stall_left = 0;
    int   items_sent = 0;
    int   runs_done  = 0;

    always #2 clk = ~clk;

    mode_relative_l2_error_sum i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mrl2_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Result side back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n || quiet_tail || !idle_on)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    // Overall time limit.
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic in_item_t coeff(logic [31:0] vr, logic [31:0] vi,
                                       logic [31:0] rr, logic [31:0] ri,
                                       logic eom, logic eoa);
        in_item_t it;
        it.var_re = vr;
        it.var_im = vi;
        it.ref_re = rr;
        it.ref_im = ri;
        it.end_of_mode = eom;
        it.end_of_all = eoa;
        return it;
    endfunction

    // Coefficient value: extremes, small Q16.16 values or any 32-bit pattern.
    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0000_0000;
                   default: return 32'hFFFF_FFFF;
               endcase
            1, 2, 3: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    // Present one transaction, with an optional idle burst first.
    task automatic send(in_item_t it);
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Stop sending, let every awaited total arrive, then allow the block to settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    // Write the offset register while the block is idle.
    task automatic write_eta(logic [ETA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One run of 1 to 4 modes ending in an end-of-all transaction.
    task automatic random_run();
        int        modes;
        int        len;
        logic      messy;
        in_item_t  it;
        modes = $urandom_range(1, 4);
        messy = ($urandom_range(0, 9) == 0);
        for (int m = 0; m < modes; m++) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                it = coeff(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                           k == len - 1, (m == modes - 1) && (k == len - 1));
                // Broken runs place mode ends at random.
                if (messy)
                    it.end_of_mode = $urandom_range(0, 1);
                if (it.end_of_all && $urandom_range(0, 7) == 0)
                    it.end_of_mode = 1'b0;
                send(it);
            end
        end
        runs_done++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of eta: plain modes, extremes, and energy overflow in one mode.
        send(coeff(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0, 1'b0));
        send(coeff(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1, 1'b0));
        send(coeff(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1));
        send(coeff(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0));
        send(coeff(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1));

        // Zero eta: zero over zero, then a nonzero error over a zero divisor.
        write_eta(32'h0);
        send(coeff(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));
        send(coeff(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));

        // Smallest nonzero eta: large quotients overflow the running total.
        write_eta(32'h1);
        send(coeff(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b0));
        send(coeff(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b0));
        send(coeff(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));

        // Largest eta.
        write_eta(32'hFFFF_FFFF);
        send(coeff(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0));
        send(coeff(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send(coeff(32'h0000_0001, 32'hFFFF_0000, 32'h1234_5678, 32'hEDCB_A987, 1'b1, 1'b1));

        // Random runs, a new eta setting for each group of runs.
        while (items_sent < 490 || runs_done < 50) begin
            case ($urandom_range(0, 5))
                0: write_eta($urandom());
                1: write_eta($urandom_range(0, 255));
                2: write_eta(32'h0001_0000);
                3: write_eta(ETA_RESET);
                4: write_eta(32'h0);
                default: write_eta($urandom_range(0, 32'h00FF_FFFF));
            endcase
            idle_on <= ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6)) begin
                random_run();
                if (items_sent >= 450)
                    quiet_tail <= 1'b1;
            end
        end

        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/mrl2_pkg.sv
design/mrl2_isqrt.sv
design/mrl2_div.sv
design/mrl2_datapath.sv
design/mrl2_ctrl.sv
design/mode_relative_l2_error_sum.sv
tb/mrl2_checker.sv
tb/testbench.sv
